// ----- hw/rtl/mgcc_pkg.sv -----
package mgcc_pkg;

   localparam int IN_WIDTH   = 80;
   localparam int OUT_WIDTH  = 56;
   localparam int NODE_WIDTH = 10;
   localparam int OFF_WIDTH  = 14;
   localparam int CODE_WIDTH = 12;
   localparam int MID_WIDTH  = 9;
   localparam int CNT_WIDTH  = 32;

   localparam logic [CNT_WIDTH-1:0] CNT_MAX = '1;

   typedef enum logic [2:0] {
      OP_LOAD_OFFSET   = 3'd0,
      OP_LOAD_NEIGHBOR = 3'd1,
      OP_LOAD_TABLE    = 3'd2,
      OP_CLASSIFY      = 3'd3,
      OP_READ_COUNTER  = 3'd4
   } opcode_type;

   typedef enum logic [0:0] {
      CSR_DIRECTED   = 1'b0,
      CSR_GROUP_SIZE = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_RD_WAIT,
      ST_PAIR,
      ST_OFF_HI,
      ST_OFF_WAIT,
      ST_SEARCH,
      ST_NB_WAIT,
      ST_TABLE,
      ST_TABLE_WAIT,
      ST_CNT_RD,
      ST_CNT_WR,
      ST_DONE
   } state_type;

endpackage

// ----- hw/rtl/motif_group_classify_count.sv -----
// From its accept cycle a load writes its memory and a counter read waits on the
// counter memory; classify walks the node pairs, skipping diagonal and row-end
// slots, looks up each pair by its offsets and a binary search (one neighbor memory
// read per step), maps the code via the table and increments each node's counter.
// One item in flight; a stalled result holds the block in its last state.
// Reset: synchronous; then all MAX_NODES*MOTIF_IDS counter entries (262144 by
// default) are cleared, one entry per cycle, before req_tready rises.
module motif_group_classify_count
   import mgcc_pkg::*;
#(
   parameter int MAX_NODES    = 1024,
   parameter int MAX_EDGES    = 8192,
   parameter int CODE_ENTRIES = 4096,
   parameter int MOTIF_IDS    = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // opcode[2:0], address[15:3], load_value[30:16], node_first[40:31],
   // node_second[50:41], node_third[60:51], node_fourth[70:61], motif_select[78:71]
   input  logic [IN_WIDTH-1:0]  req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // group_code[11:0], motif_id[20:12], counter_value[52:21], saturated[53]
   output logic [OUT_WIDTH-1:0] rsp_tdata,
   input  logic                 csr_wen,
   input  logic [0:0]           csr_index,
   input  logic [2:0]           csr_wdata
);

   localparam int DEPTH = MAX_NODES * MOTIF_IDS;
   localparam int CW    = $clog2(DEPTH);
   localparam int OAW   = $clog2(MAX_NODES + 1);
   localparam int NAW   = $clog2(MAX_EDGES);
   localparam int TAW   = $clog2(CODE_ENTRIES);
   localparam int EW    = $clog2(MAX_EDGES + 1);
   localparam int LW    = (EW > OFF_WIDTH) ? EW : OFF_WIDTH;

   logic [OFF_WIDTH-1:0]  off_mem [MAX_NODES+1];
   logic [NODE_WIDTH-1:0] nb_mem  [MAX_EDGES];
   logic [MID_WIDTH-1:0]  tab_mem [CODE_ENTRIES];
   logic [CNT_WIDTH-1:0]  cnt_mem [DEPTH];

   logic                  off_we, nb_we, tab_we, cnt_we;
   logic [OAW-1:0]        off_wa, off_ra;
   logic [NAW-1:0]        nb_wa, nb_ra;
   logic [TAW-1:0]        tab_wa, tab_ra;
   logic [CW-1:0]         cnt_wa, cnt_ra;
   logic [CNT_WIDTH-1:0]  cnt_wd;
   logic [OFF_WIDTH-1:0]  off_rd;
   logic [NODE_WIDTH-1:0] nb_rd;
   logic [MID_WIDTH-1:0]  tab_rd;
   logic [CNT_WIDTH-1:0]  cnt_rd;

   state_type state_ff, state_in;
   logic                  dir_ff, dir_in;
   logic [2:0]            gsize_ff, gsize_in;
   logic [2:0]            op_ff, op_in;
   logic [12:0]           addr_ff, addr_in;
   logic [14:0]           lv_ff, lv_in;
   logic [NODE_WIDTH-1:0] n0_ff, n1_ff, n2_ff, n3_ff;
   logic [NODE_WIDTH-1:0] n0_in, n1_in, n2_in, n3_in;
   logic [7:0]            sel_ff, sel_in;
   logic [2:0]            i_ff, i_in, j_ff, j_in;
   logic [3:0]            bit_ff, bit_in;
   logic [CODE_WIDTH-1:0] code_ff, code_in;
   logic [MID_WIDTH-1:0]  mid_ff, mid_in;
   logic [CNT_WIDTH-1:0]  cval_ff, cval_in;
   logic                  sat_ff, sat_in;
   logic [LW-1:0]         lo_ff, lo_in, hi_ff, hi_in, mid_pos_ff, mid_pos_in;
   logic [CW-1:0]         clr_ff, clr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_WIDTH-1:0]  rsp_data_ff, rsp_data_in;

   logic [2:0]            n_nodes;
   logic [NODE_WIDTH-1:0] p_node, q_node, k_node;
   logic                  p_ok, q_ok, k_ok, motif_ok;
   logic [LW-1:0]         lo_next_mid;
   logic [CW-1:0]         cnt_idx, rd_idx;
   logic [CNT_WIDTH-1:0]  cnt_inc;

   function automatic logic [NODE_WIDTH-1:0] pick(input logic [2:0] k,
         input logic [NODE_WIDTH-1:0] a, b, c, d);
      unique case (k[1:0])
         2'd0: pick = a;
         2'd1: pick = b;
         2'd2: pick = c;
         default: pick = d;
      endcase
   endfunction

   always_ff @(posedge clock) begin
      if (off_we) off_mem[off_wa] <= lv_ff[OFF_WIDTH-1:0];
      off_rd <= off_mem[off_ra];
   end

   always_ff @(posedge clock) begin
      if (nb_we) nb_mem[nb_wa] <= lv_ff[NODE_WIDTH-1:0];
      nb_rd <= nb_mem[nb_ra];
   end

   always_ff @(posedge clock) begin
      if (tab_we) tab_mem[tab_wa] <= lv_ff[MID_WIDTH-1:0];
      tab_rd <= tab_mem[tab_ra];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
      cnt_rd <= cnt_mem[cnt_ra];
   end

   assign n_nodes  = (gsize_ff == 3'd4) ? 3'd4 : 3'd3;
   assign p_node   = pick(i_ff, n0_ff, n1_ff, n2_ff, n3_ff);
   assign q_node   = pick(j_ff, n0_ff, n1_ff, n2_ff, n3_ff);
   assign k_node   = pick(i_ff, n0_ff, n1_ff, n2_ff, n3_ff);
   assign p_ok     = 32'(p_node) < MAX_NODES;
   assign q_ok     = 32'(q_node) < MAX_NODES;
   assign k_ok     = 32'(k_node) < MAX_NODES;
   assign motif_ok = !mid_ff[MID_WIDTH-1] && (32'(mid_ff) < MOTIF_IDS);
   assign lo_next_mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign cnt_idx  = CW'(mid_ff[MID_WIDTH-2:0]) + CW'(MOTIF_IDS) * CW'(k_node);
   assign rd_idx   = CW'(sel_ff) + CW'(MOTIF_IDS) * CW'(n0_ff);
   assign cnt_inc  = (cnt_rd == CNT_MAX) ? cnt_rd : cnt_rd + 1'b1;

   always_comb begin
      state_in = state_ff;
      dir_in = dir_ff;  gsize_in = gsize_ff;
      op_in = op_ff;  addr_in = addr_ff;  lv_in = lv_ff;
      n0_in = n0_ff;  n1_in = n1_ff;  n2_in = n2_ff;  n3_in = n3_ff;
      sel_in = sel_ff;  i_in = i_ff;  j_in = j_ff;  bit_in = bit_ff;
      code_in = code_ff;  mid_in = mid_ff;  cval_in = cval_ff;  sat_in = sat_ff;
      lo_in = lo_ff;  hi_in = hi_ff;  mid_pos_in = mid_pos_ff;  clr_in = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      off_we = 1'b0;  nb_we = 1'b0;  tab_we = 1'b0;  cnt_we = 1'b0;
      off_wa = OAW'(addr_ff);  nb_wa = NAW'(addr_ff);  tab_wa = TAW'(addr_ff);
      cnt_wa = cnt_idx;  cnt_wd = cnt_inc;
      off_ra = OAW'(p_node);  nb_ra = NAW'(mid_pos_ff);  tab_ra = TAW'(code_ff);
      cnt_ra = cnt_idx;
      req_tready = 1'b0;

      if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_DIRECTED:   dir_in = csr_wdata[0];
            CSR_GROUP_SIZE: gsize_in = csr_wdata;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            cnt_we = 1'b1;
            cnt_wa = clr_ff;
            cnt_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == DEPTH - 1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in = req_tdata[2:0];  addr_in = req_tdata[15:3];
               lv_in = req_tdata[30:16];
               n0_in = req_tdata[40:31];  n1_in = req_tdata[50:41];
               n2_in = req_tdata[60:51];  n3_in = req_tdata[70:61];
               sel_in = req_tdata[78:71];
               code_in = '0;  mid_in = '0;  cval_in = '0;  sat_in = 1'b0;
               i_in = 3'd0;  j_in = 3'd0;  bit_in = '0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            cnt_ra = rd_idx;
            priority case (op_ff)
               OP_LOAD_OFFSET:   off_we = 32'(addr_ff) < MAX_NODES + 1;
               OP_LOAD_NEIGHBOR: nb_we  = 32'(addr_ff) < MAX_EDGES;
               OP_LOAD_TABLE:    tab_we = 32'(addr_ff) < CODE_ENTRIES;
               OP_CLASSIFY: begin
                  j_in = dir_ff ? 3'd0 : 3'd1;
                  state_in = ST_PAIR;
               end
               OP_READ_COUNTER: state_in = ST_RD_WAIT;
               default: ;
            endcase
         end
         ST_RD_WAIT: begin
            if (32'(n0_ff) < MAX_NODES && 32'(sel_ff) < MOTIF_IDS) cval_in = cnt_rd;
            state_in = ST_DONE;
         end
         ST_PAIR: begin
            if (i_ff == n_nodes) begin
               state_in = ST_TABLE;
            end else if (j_ff == n_nodes) begin
               i_in = i_ff + 3'd1;
               j_in = dir_ff ? 3'd0 : i_ff + 3'd2;
            end else if (i_ff == j_ff) begin
               j_in = j_ff + 3'd1;
            end else if (!p_ok || !q_ok) begin
               bit_in = bit_ff + 4'd1;
               j_in = j_ff + 3'd1;
            end else begin
               state_in = ST_OFF_HI;
            end
         end
         ST_OFF_HI: begin
            lo_in = LW'(off_rd);
            off_ra = OAW'(p_node) + 1'b1;
            state_in = ST_OFF_WAIT;
         end
         ST_OFF_WAIT: begin
            hi_in = (LW'(off_rd) > LW'(MAX_EDGES)) ? LW'(MAX_EDGES) : LW'(off_rd);
            state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            nb_ra = NAW'(lo_next_mid);
            if (lo_ff < hi_ff) begin
               mid_pos_in = lo_next_mid;
               state_in = ST_NB_WAIT;
            end else begin
               bit_in = bit_ff + 4'd1;
               j_in = j_ff + 3'd1;
               state_in = ST_PAIR;
            end
         end
         ST_NB_WAIT: begin
            if (nb_rd == q_node) begin
               code_in = code_ff | (CODE_WIDTH'(1) << bit_ff);
               bit_in = bit_ff + 4'd1;
               j_in = j_ff + 3'd1;
               state_in = ST_PAIR;
            end else begin
               if (nb_rd > q_node) hi_in = mid_pos_ff;
               else lo_in = mid_pos_ff + 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_TABLE: begin
            state_in = ST_TABLE_WAIT;
         end
         ST_TABLE_WAIT: begin
            mid_in = (32'(code_ff) < CODE_ENTRIES) ? tab_rd : '1;
            i_in = 3'd0;
            state_in = ST_CNT_RD;
         end
         ST_CNT_RD: begin
            if (!motif_ok || i_ff == n_nodes) state_in = ST_DONE;
            else if (!k_ok) i_in = i_ff + 3'd1;
            else state_in = ST_CNT_WR;
         end
         ST_CNT_WR: begin
            cnt_we = 1'b1;
            if (cnt_inc == CNT_MAX) sat_in = 1'b1;
            i_in = i_ff + 3'd1;
            state_in = ST_CNT_RD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {2'b0, sat_ff, cval_ff, mid_ff, code_ff};
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         dir_ff <= 1'b0;
         gsize_ff <= 3'd3;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         dir_ff <= dir_in;
         gsize_ff <= gsize_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;  addr_ff <= addr_in;  lv_ff <= lv_in;
      n0_ff <= n0_in;  n1_ff <= n1_in;  n2_ff <= n2_in;  n3_ff <= n3_in;
      sel_ff <= sel_in;  i_ff <= i_in;  j_ff <= j_in;  bit_ff <= bit_in;
      code_ff <= code_in;  mid_ff <= mid_in;  cval_ff <= cval_in;  sat_ff <= sat_in;
      lo_ff <= lo_in;  hi_ff <= hi_in;  mid_pos_ff <= mid_pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- hw/rtl/mgcc_checker.sv -----
module mgcc_checker
   import mgcc_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [OUT_WIDTH-1:0] rsp_tdata
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid && !req_tready)
      else $error("busy right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[55:54] == 2'b00)
      else $error("result pad bits set");

   a_sat_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[53] |-> !rsp_tdata[20] && rsp_tdata[52:21] == '0)
      else $error("saturation flagged without a counted motif");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");

endmodule

bind motif_group_classify_count mgcc_checker u_mgcc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
